[hdl/utx_pkg.sv]
// ----------------------------------------------------------------------------
// utx_pkg
// Shared types and constants of the UTF-8/16/32 transcoder: conversion codes,
// register indexes, the queue word between front and back, and back states.
// ----------------------------------------------------------------------------
package utx_pkg;

  // Code point width: UTF-8 decoding yields at most 21 bits
  localparam int CP_W = 21;
  typedef logic [CP_W-1:0] cp_t;

  localparam cp_t CP_MAX = 21'h10FFFF;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONVERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BE     = 2'd2;

  // Conversion codes
  localparam logic [2:0] CONV_U8TO16  = 3'd0;
  localparam logic [2:0] CONV_U8TO32  = 3'd1;
  localparam logic [2:0] CONV_U16TO8  = 3'd2;
  localparam logic [2:0] CONV_U16TO32 = 3'd3;
  localparam logic [2:0] CONV_U32TO8  = 3'd4;
  localparam logic [2:0] CONV_U32TO16 = 3'd5;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [2:0] conversion;
    logic       src_be;
    logic       dst_be;
  } cfg_t;

  // One decoded input byte: an optional code point, an optional trailing
  // U+0000 (lone surrogate case) and an optional error result
  typedef struct packed {
    cp_t  cp;
    logic has_cp;
    logic has_zero;
    logic err;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  // Encoded bytes of one code point, first byte at index 0
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [1:0]      last_idx;
  } enc_t;

  // Segment of a queue word the back end is serializing
  typedef enum logic [1:0] {
    SEG_CP,
    SEG_ZERO,
    SEG_ERR
  } seg_t;

endpackage

[hdl/utx_if.sv]
// ----------------------------------------------------------------------------
// utx_if
// Valid/ready channel interfaces of the transcoder: input bytes, result
// bytes and configuration writes.
// ----------------------------------------------------------------------------
interface utx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface utx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

interface utx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [utx_pkg::CFG_IDX_W-1:0]  index;
  logic [utx_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

[hdl/unicode_utf_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// unicode_utf_transcoder_unit
// Converts a byte stream between UTF-8, UTF-16 and UTF-32.
//
//   channel  dir  payload                          handshake
//   in_ch    in   data_byte[8], end_of_stream      valid/ready
//   out_ch   out  out_byte[8], last, error         valid/ready
//   cfg_ch   in   index[2], wdata[3]               valid/ready, always ready
//
// An input byte is taken whenever the 4-word queue has room.
// Results leave at one byte per cycle while out_ch is ready; an input byte
// gives 0 to 8 result bytes (none if it only extends a unit; 4 per code
// point for UTF-8 to UTF-32), sent by the byte serializer in the back end.
// Reset (rst_n low, synchronous) clears the stream state, the queue and the
// output, and sets conversion to UTF-8 to UTF-32 with little-endian units.
// Either side may stall on its own; a waiting result blocks input only once
// the queue is full.
// ----------------------------------------------------------------------------
module unicode_utf_transcoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  utx_in_if.sink     in_ch,
  utx_out_if.source  out_ch,
  utx_cfg_if.sink    cfg_ch
);
  import utx_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     push;
  entry_t   push_word;
  logic     pop;
  entry_t   head;
  fifo_st_t fifo_st;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CONVERSION: cfg_nxt.conversion = cfg_ch.wdata[2:0];
        REG_SRC_BE:     cfg_nxt.src_be     = cfg_ch.wdata[0];
        REG_DST_BE:     cfg_nxt.dst_be     = cfg_ch.wdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conversion <= CONV_U8TO32;
      cfg_r.src_be     <= 1'b0;
      cfg_r.dst_be     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  utx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_word (push_word)
  );

  utx_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_word),
    .pop   (pop),
    .dout  (head),
    .st    (fifo_st)
  );

  utx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (head),
    .fifo_st (fifo_st),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // The error result closes the results of its input byte
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.last)
    else $error("error result not marked last");

  // The error result carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.out_byte == 8'h00)
    else $error("error result with nonzero byte");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

[hdl/utx_front.sv]
// ----------------------------------------------------------------------------
// utx_front
// Accepts source bytes, assembles code units, decodes UTF-8 and pairs
// surrogates. Each byte that causes results pushes one word to the queue.
// ----------------------------------------------------------------------------
module utx_front (
  input  logic              clk,
  input  logic              rst_n,
  utx_in_if.sink            in_ch,
  input  utx_pkg::cfg_t     cfg,
  input  utx_pkg::fifo_st_t fifo_st,
  output logic              push,
  output utx_pkg::entry_t   push_word
);
  import utx_pkg::*;

  logic [31:0] buf_r, buf_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [15:0] hsur_r, hsur_nxt;
  logic        swait_r, swait_nxt;
  logic        lat_r, lat_nxt;

  logic        in_fire;
  logic [31:0] nb;
  logic [2:0]  nh;
  logic [7:0]  lead;
  logic [2:0]  len;
  logic [15:0] u16;
  logic [31:0] u32;
  logic        ok;
  logic        emit;
  logic        zero;
  cp_t         cp;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b inside {[8'h00:8'h7F]})      r = 3'd1;
    else if (b inside {[8'hC2:8'hDF]}) r = 3'd2;
    else if (b inside {[8'hE0:8'hEF]}) r = 3'd3;
    else if (b inside {[8'hF0:8'hF7]}) r = 3'd4;
    return r;
  endfunction

  function automatic logic is_surr(input logic [15:0] u);
    return u inside {[16'hD800:16'hDFFF]};
  endfunction

  function automatic logic is_high(input logic [15:0] u);
    return u inside {[16'hD800:16'hDBFF]};
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return u inside {[16'hDC00:16'hDFFF]};
  endfunction

  // Accept whenever the queue has room
  assign in_ch.ready = !fifo_st.full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign nb  = {buf_r[23:0], in_ch.data_byte};
  assign nh  = held_r + 3'd1;
  assign u16 = cfg.src_be ? nb[15:0] : {nb[7:0], nb[15:8]};
  assign u32 = cfg.src_be ? nb : {nb[7:0], nb[15:8], nb[23:16], nb[31:24]};

  // Lead byte of a partly assembled UTF-8 sequence
  always_comb begin
    case (held_r)
      3'd1:    lead = buf_r[7:0];
      3'd2:    lead = buf_r[15:8];
      3'd3:    lead = buf_r[23:16];
      default: lead = 8'h00;
    endcase
    len = lead_len(lead);
  end

  // Decode one byte and work out the next state
  always_comb begin
    buf_nxt   = buf_r;
    held_nxt  = held_r;
    hsur_nxt  = hsur_r;
    swait_nxt = swait_r;
    lat_nxt   = lat_r;
    ok        = 1'b1;
    emit      = 1'b0;
    zero      = 1'b0;
    cp        = '0;

    if (in_fire && !lat_r && !(cfg.conversion > CONV_U32TO16)) begin
      if (cfg.conversion == CONV_U8TO16 || cfg.conversion == CONV_U8TO32) begin
        if (held_r == 3'd0) begin
          case (lead_len(in_ch.data_byte))
            3'd0: ok = 1'b0;
            3'd1: begin
              emit = 1'b1;
              cp   = {13'd0, in_ch.data_byte};
            end
            default: begin
              buf_nxt  = {24'd0, in_ch.data_byte};
              held_nxt = 3'd1;
            end
          endcase
        end else if (held_r > 3'd3 || len < 3'd2 || held_r >= len) begin
          ok = 1'b0;
        end else if (in_ch.data_byte[7:6] != 2'b10) begin
          ok = 1'b0;
        end else if (held_r == 3'd1 &&
                     ((len == 3'd2 && lead[4:1] == 4'd0) ||
                      (len == 3'd3 && lead[3:0] == 4'd0 && !in_ch.data_byte[5]) ||
                      (len == 3'd4 && lead[2:0] == 3'd0 &&
                       in_ch.data_byte[5:4] == 2'b00))) begin
          // overlong form
          ok = 1'b0;
        end else if (nh < len) begin
          buf_nxt  = nb;
          held_nxt = nh;
        end else begin
          buf_nxt  = '0;
          held_nxt = 3'd0;
          emit     = 1'b1;
          case (len)
            3'd2:    cp = {10'd0, lead[4:0], nb[5:0]};
            3'd3:    cp = {5'd0, lead[3:0], nb[13:8], nb[5:0]};
            default: cp = {lead[2:0], nb[21:16], nb[13:8], nb[5:0]};
          endcase
          // UTF-16 destination cannot carry values above the range
          if (cfg.conversion == CONV_U8TO16 && cp > CP_MAX) begin
            ok   = 1'b0;
            emit = 1'b0;
          end
        end
      end else if (cfg.conversion == CONV_U16TO8 || cfg.conversion == CONV_U16TO32) begin
        if (nh < 3'd2) begin
          buf_nxt  = nb;
          held_nxt = nh;
        end else begin
          buf_nxt  = '0;
          held_nxt = 3'd0;
          if (swait_r) begin
            swait_nxt = 1'b0;
            hsur_nxt  = '0;
            if (is_high(hsur_r) && is_low(u16)) begin
              emit = 1'b1;
              cp   = 21'h10000 + {1'b0, hsur_r[9:0], u16[9:0]};
            end else if (u16 != 16'd0) begin
              ok = 1'b0;
            end else begin
              // lone surrogate, then U+0000
              emit = 1'b1;
              zero = 1'b1;
              cp   = {5'd0, hsur_r};
            end
          end else if (is_surr(u16)) begin
            hsur_nxt  = u16;
            swait_nxt = 1'b1;
          end else begin
            emit = 1'b1;
            cp   = {5'd0, u16};
          end
        end
      end else begin
        if (nh < 3'd4) begin
          buf_nxt  = nb;
          held_nxt = nh;
        end else begin
          buf_nxt  = '0;
          held_nxt = 3'd0;
          if (u32 > {11'd0, CP_MAX}) begin
            ok = 1'b0;
          end else begin
            emit = 1'b1;
            cp   = u32[CP_W-1:0];
          end
        end
      end

      // Truncated end of stream
      if (ok && in_ch.end_of_stream && (held_nxt != 3'd0 || swait_nxt)) begin
        ok = 1'b0;
      end
      if (!ok) begin
        lat_nxt = 1'b1;
      end
    end

    // End of stream clears everything, a latched error too
    if (in_fire && in_ch.end_of_stream) begin
      buf_nxt   = '0;
      held_nxt  = 3'd0;
      hsur_nxt  = '0;
      swait_nxt = 1'b0;
      lat_nxt   = 1'b0;
    end
  end

  // Queue word
  assign push               = emit || !ok;
  assign push_word.cp       = cp;
  assign push_word.has_cp   = emit;
  assign push_word.has_zero = zero;
  assign push_word.err      = !ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      held_r  <= 3'd0;
      hsur_r  <= '0;
      swait_r <= 1'b0;
      lat_r   <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      hsur_r  <= hsur_nxt;
      swait_r <= swait_nxt;
      lat_r   <= lat_nxt;
    end
  end

endmodule

[hdl/utx_fifo.sv]
// ----------------------------------------------------------------------------
// utx_fifo
// Short register queue that decouples the decoding front from the byte
// serializing back end.
// ----------------------------------------------------------------------------
module utx_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utx_pkg::entry_t   din,
  input  logic              pop,
  output utx_pkg::entry_t   dout,
  output utx_pkg::fifo_st_t st
);
  import utx_pkg::*;

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt;
  logic [FIFO_AW-1:0]   rp_r, rp_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign st.full  = (cnt_r == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign dout     = mem_r[rp_r];

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[hdl/utx_back.sv]
// ----------------------------------------------------------------------------
// utx_back
// Takes decoded queue words, encodes each code point in destination form and
// sends one byte per cycle through an output register while out_ch is ready.
// ----------------------------------------------------------------------------
module utx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  utx_pkg::cfg_t     cfg,
  input  utx_pkg::entry_t   head,
  input  utx_pkg::fifo_st_t fifo_st,
  output logic              pop,
  utx_out_if.source         out_ch
);
  import utx_pkg::*;

  logic       ent_valid_r, ent_valid_nxt;
  entry_t     ent_r, ent_nxt;
  seg_t       seg_r, seg_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_err_r, out_err_nxt;

  cp_t        cur_cp;
  enc_t       enc;
  logic [7:0] cur_byte;
  logic [1:0] cur_last_idx;
  logic       seg_done;
  logic       has_next;
  seg_t       next_seg;
  logic       out_free;
  logic       emit;
  logic       ent_done;

  function automatic enc_t encode(input cp_t cp, input cfg_t c);
    enc_t        e;
    logic [15:0] u;
    logic [19:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [31:0] w;
    e.b        = '0;
    e.last_idx = 2'd0;
    u          = cp[15:0];
    v          = 20'(cp - 21'h10000);
    hi         = {6'b110110, v[19:10]};
    lo         = {6'b110111, v[9:0]};
    w          = {11'd0, cp};
    case (c.conversion)
      CONV_U8TO16, CONV_U32TO16: begin
        if (cp < 21'h10000) begin
          e.b[0]     = c.dst_be ? u[15:8] : u[7:0];
          e.b[1]     = c.dst_be ? u[7:0] : u[15:8];
          e.last_idx = 2'd1;
        end else begin
          e.b[0]     = c.dst_be ? hi[15:8] : hi[7:0];
          e.b[1]     = c.dst_be ? hi[7:0] : hi[15:8];
          e.b[2]     = c.dst_be ? lo[15:8] : lo[7:0];
          e.b[3]     = c.dst_be ? lo[7:0] : lo[15:8];
          e.last_idx = 2'd3;
        end
      end
      CONV_U8TO32, CONV_U16TO32: begin
        e.b[0]     = c.dst_be ? w[31:24] : w[7:0];
        e.b[1]     = c.dst_be ? w[23:16] : w[15:8];
        e.b[2]     = c.dst_be ? w[15:8] : w[23:16];
        e.b[3]     = c.dst_be ? w[7:0] : w[31:24];
        e.last_idx = 2'd3;
      end
      default: begin
        if (cp <= 21'h7F) begin
          e.b[0]     = cp[7:0];
        end else if (cp <= 21'h7FF) begin
          e.b[0]     = {3'b110, cp[10:6]};
          e.b[1]     = {2'b10, cp[5:0]};
          e.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
          e.b[0]     = {4'b1110, cp[15:12]};
          e.b[1]     = {2'b10, cp[11:6]};
          e.b[2]     = {2'b10, cp[5:0]};
          e.last_idx = 2'd2;
        end else begin
          e.b[0]     = {5'b11110, cp[20:18]};
          e.b[1]     = {2'b10, cp[17:12]};
          e.b[2]     = {2'b10, cp[11:6]};
          e.b[3]     = {2'b10, cp[5:0]};
          e.last_idx = 2'd3;
        end
      end
    endcase
    return e;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;

  // Encode the current segment and pick its byte
  always_comb begin
    cur_cp = (seg_r == SEG_CP) ? ent_r.cp : '0;
    enc    = encode(cur_cp, cfg);
    if (seg_r == SEG_ERR) begin
      cur_byte     = 8'h00;
      cur_last_idx = 2'd0;
    end else begin
      cur_byte     = enc.b[idx_r];
      cur_last_idx = enc.last_idx;
    end
    seg_done = (idx_r == cur_last_idx);
    case (seg_r)
      SEG_CP: begin
        has_next = ent_r.has_zero || ent_r.err;
        next_seg = ent_r.has_zero ? SEG_ZERO : SEG_ERR;
      end
      SEG_ZERO: begin
        has_next = ent_r.err;
        next_seg = SEG_ERR;
      end
      default: begin
        has_next = 1'b0;
        next_seg = SEG_ERR;
      end
    endcase
    emit     = ent_valid_r && out_free;
    ent_done = emit && seg_done && !has_next;
    pop      = !ent_valid_r || ent_done;
  end

  // Next state: step bytes and segments, load the next word
  always_comb begin
    ent_valid_nxt = ent_valid_r;
    ent_nxt       = ent_r;
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    if (emit) begin
      if (!seg_done) begin
        idx_nxt = idx_r + 2'd1;
      end else if (has_next) begin
        seg_nxt = next_seg;
        idx_nxt = 2'd0;
      end else begin
        ent_valid_nxt = 1'b0;
      end
    end
    if (pop && !fifo_st.empty) begin
      ent_valid_nxt = 1'b1;
      ent_nxt       = head;
      seg_nxt       = head.has_cp ? SEG_CP : SEG_ERR;
      idx_nxt       = 2'd0;
    end
  end

  // Output register: load when free, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = seg_done && !has_next;
      out_err_nxt   = (seg_r == SEG_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      seg_r       <= SEG_CP;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
      seg_r       <= seg_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.error    = out_err_r;

endmodule
